/* src/rle_pkg.sv */
// Package for the byte run-length encoder: item types, codes and constants.
// Used by rle_byte_encoder, rle_emit and rle_checker; depends on nothing.
`default_nettype none

package rle_pkg;

   localparam logic [7:0] MARK_BYTE   = 8'h80;
   localparam logic [7:0] ESC_BYTE    = 8'h81;
   localparam logic [6:0] COUNT_CAP   = 7'd127;
   localparam logic [5:0] MIN_CAP     = 6'd32;

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN = 1'd1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_of_item;
      logic       stream_done;
   } rsp_type;

   // run handed to the emitter
   typedef struct packed {
      logic [7:0] value;
      logic [6:0] count;
      logic       marker;
   } run_load_type;

   typedef enum logic {
      ST_IDLE,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

/* src/rle_emit.sv */
// Run emitter: turns one held run into code bytes, one byte per advance.
// Uses rle_pkg (run_load_type, marker and escape codes).
`default_nettype none

module rle_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_en,
   input  wire rle_pkg::run_load_type load,
   input  wire logic                  advance,
   output logic [7:0]                 code_byte,
   output logic                       run_done
);

   logic [7:0] value_ff, value_in;
   logic [6:0] count_ff, count_in;
   logic [6:0] left_ff, left_in;
   logic       marker_ff, marker_in;
   logic       two_ff, two_in;
   logic       phase_ff, phase_in;
   logic       byte_done;

   // two-byte codes: marker pair, or escaped literal
   assign byte_done = !two_ff || phase_ff;
   assign run_done  = byte_done && (left_ff == 7'd1);

   always_comb begin
      if (!two_ff || phase_ff) begin
         code_byte = value_ff;
      end else if (marker_ff) begin
         code_byte = rle_pkg::MARK_BYTE | {1'b0, count_ff};
      end else begin
         code_byte = rle_pkg::ESC_BYTE;
      end
   end

   always_comb begin
      value_in  = value_ff;
      count_in  = count_ff;
      left_in   = left_ff;
      marker_in = marker_ff;
      two_in    = two_ff;
      phase_in  = phase_ff;
      if (load_en) begin
         value_in  = load.value;
         count_in  = load.count;
         marker_in = load.marker;
         left_in   = load.marker ? 7'd1 : load.count;
         two_in    = load.marker || (load.value >= rle_pkg::MARK_BYTE);
         phase_in  = 1'b0;
      end else if (advance) begin
         if (byte_done) begin
            phase_in = 1'b0;
            left_in  = left_ff - 7'd1;
         end else begin
            phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      count_ff  <= count_in;
      left_ff   <= left_in;
      marker_ff <= marker_in;
      two_ff    <= two_in;
      if (reset) begin
         phase_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

/* src/rle_byte_encoder.sv */
// Byte run-length encoder top level: accept logic, run state, output register.
// Depends on rle_pkg and rle_emit.
//
// One raw byte is taken per item. A byte that extends the held run gives no
// result. An item that flushes a run is taken in, then gives its code bytes
// (1 to 64 bytes) one at a time, since the run emitter puts out a single
// byte per cycle while the output is not stalled; the next item is taken the
// cycle after the last byte enters the output register. req_stall is high
// while a flush is under way. Output stalls hold the emitter in place. The
// two CSRs (min run length, max run length) are sampled when a run is
// extended or flushed.
`default_nettype none

module rle_byte_encoder (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rle_pkg::req_type                 req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rle_pkg::rsp_type                      rsp_data,
   input  wire logic                             csr_write_en,
   input  wire logic [rle_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rle_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   rle_pkg::state_type state_ff, state_in;

   logic [5:0] min_run_ff, min_run_in;
   logic [6:0] max_run_ff, max_run_in;
   logic [7:0] held_ff, held_in;
   logic [6:0] count_ff, count_in;
   logic       pend_ff, pend_in;   // eos flush of the new run still to do
   logic       eos_ff, eos_in;

   logic             rsp_valid_ff, rsp_valid_in;
   rle_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [5:0] eff_min;
   logic [6:0] eff_max;
   logic       accept, extend, out_free, advance;
   logic       load_en, run_done;
   logic [7:0] code_byte;
   rle_pkg::run_load_type load;

   // zero acts as one; minimum saturates at 32
   always_comb begin
      if (min_run_ff == 6'd0) begin
         eff_min = 6'd1;
      end else if (min_run_ff > rle_pkg::MIN_CAP) begin
         eff_min = rle_pkg::MIN_CAP;
      end else begin
         eff_min = min_run_ff;
      end
      eff_max = (max_run_ff == 7'd0) ? 7'd1 : max_run_ff;
   end

   assign req_stall = (state_ff == rle_pkg::ST_FLUSH);
   assign accept    = req_valid && !req_stall;
   assign extend    = (count_ff != 7'd0) && (req_data.data_byte == held_ff)
                      && (count_ff < eff_max);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = (state_ff == rle_pkg::ST_FLUSH) && out_free;

   // CSR writes
   always_comb begin
      min_run_in = min_run_ff;
      max_run_in = max_run_ff;
      if (csr_write_en) begin
         case (csr_index)
            rle_pkg::CSR_MIN_RUN: min_run_in = csr_wdata[5:0];
            rle_pkg::CSR_MAX_RUN: max_run_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer: run bookkeeping and emitter loads
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      eos_in       = eos_ff;
      load_en      = 1'b0;
      load.value   = held_ff;
      load.count   = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rle_pkg::ST_IDLE: begin
            if (accept) begin
               eos_in = req_data.end_of_stream;
               pend_in = 1'b0;
               if (extend) begin
                  if (req_data.end_of_stream) begin
                     load_en    = 1'b1;
                     load.count = count_ff + 7'd1;
                     count_in   = 7'd0;
                     state_in   = rle_pkg::ST_FLUSH;
                  end else begin
                     count_in = count_ff + 7'd1;
                  end
               end else if (count_ff != 7'd0) begin
                  // flush the old run, start a new one
                  load_en  = 1'b1;
                  held_in  = req_data.data_byte;
                  count_in = 7'd1;
                  pend_in  = req_data.end_of_stream;
                  state_in = rle_pkg::ST_FLUSH;
               end else begin
                  held_in = req_data.data_byte;
                  if (req_data.end_of_stream) begin
                     load_en    = 1'b1;
                     load.value = req_data.data_byte;
                     load.count = 7'd1;
                     count_in   = 7'd0;
                     state_in   = rle_pkg::ST_FLUSH;
                  end else begin
                     count_in = 7'd1;
                  end
               end
            end
         end
         rle_pkg::ST_FLUSH: begin
            if (advance) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.code_byte    = code_byte;
               rsp_data_in.last_of_item = run_done && !pend_ff;
               rsp_data_in.stream_done  = run_done && !pend_ff && eos_ff;
               if (run_done) begin
                  if (pend_ff) begin
                     // end of stream: flush the run just started
                     load_en  = 1'b1;
                     count_in = 7'd0;
                     pend_in  = 1'b0;
                  end else begin
                     state_in = rle_pkg::ST_IDLE;
                  end
               end
            end
         end
         default: state_in = rle_pkg::ST_IDLE;
      endcase

      load.marker = (load.count >= {1'b0, eff_min});
   end

   rle_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .load      (load),
      .advance   (advance && !run_done),
      .code_byte (code_byte),
      .run_done  (run_done)
   );

   always_ff @(posedge clock) begin
      held_ff     <= held_in;
      eos_ff      <= eos_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= rle_pkg::ST_IDLE;
         min_run_ff   <= 6'd2;
         max_run_ff   <= rle_pkg::COUNT_CAP;
         count_ff     <= 7'd0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_run_ff   <= min_run_in;
         max_run_ff   <= max_run_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* src/rle_checker.sv */
// Port-level checker for rle_byte_encoder, attached by the bind below.
// Depends on rle_pkg.
`default_nettype none

module rle_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire rle_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire rle_pkg::rsp_type rsp_data
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.stream_done |-> rsp_data.last_of_item)
      else $error("stream_done without last_of_item");

   // end of stream always flushes, so the block is busy next cycle
   a_eos_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.end_of_stream |=> req_stall)
      else $error("end of stream item did not start a flush");

   // while an item's results are still coming, no new item is taken
   a_mid_item_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_item |-> req_stall)
      else $error("input taken in the middle of an item's results");

endmodule

bind rle_byte_encoder rle_checker u_rle_checker (.*);

`default_nettype wire

/* dv/rle_byte_encoder_tb.sv */
// Testbench for rle_byte_encoder: drives raw bytes and CSR writes, predicts the
// encoded byte stream and checks every result byte. Depends on rle_pkg and the RTL.
`timescale 1ns / 100ps

module rle_byte_encoder_tb;

   // Expected code bytes, built from each accepted item by a copy of the
   // encoder's run state and register settings.
   class rle_code_scoreboard;
      rle_pkg::rsp_type expected_codes[$];
      logic [7:0] held_value;
      logic [6:0] run_len;
      logic [5:0] min_run_reg;
      logic [6:0] max_run_reg;
      int         errors;
      int         items_seen;
      int         bytes_checked;
      int         streams_closed;
      int         reg_writes;

      function new();
         held_value  = 8'h00;
         run_len     = 7'd0;
         min_run_reg = 6'd2;
         max_run_reg = 7'd127;
      endfunction

      function void set_reg(logic [rle_pkg::CSR_IDX_W-1:0] idx,
                            logic [rle_pkg::CSR_DATA_W-1:0] val);
         reg_writes++;
         if (idx == rle_pkg::CSR_MIN_RUN)
            min_run_reg = val[5:0];
         else if (idx == rle_pkg::CSR_MAX_RUN)
            max_run_reg = val;
      endfunction

      // zero acts as one, anything past 32 is clamped
      function logic [6:0] min_run_used();
         logic [6:0] m = {1'b0, min_run_reg};
         if (m == 7'd0) m = 7'd1;
         if (m > {1'b0, rle_pkg::MIN_CAP}) m = {1'b0, rle_pkg::MIN_CAP};
         return m;
      endfunction

      function logic [6:0] max_run_used();
         logic [6:0] m = max_run_reg;
         if (m == 7'd0) m = 7'd1;
         return m;
      endfunction

      function void push_code(logic [7:0] b);
         rle_pkg::rsp_type r;
         r.code_byte    = b;
         r.last_of_item = 1'b0;
         r.stream_done  = 1'b0;
         expected_codes.push_back(r);
      endfunction

      function void flush_run();
         if (run_len == 7'd0) return;
         if (run_len >= min_run_used()) begin
            push_code(rle_pkg::MARK_BYTE | {1'b0, run_len});
            push_code(held_value);
         end else begin
            for (int k = 0; k < run_len; k++) begin
               if (held_value < rle_pkg::MARK_BYTE) begin
                  push_code(held_value);
               end else begin
                  push_code(rle_pkg::ESC_BYTE);
                  push_code(held_value);
               end
            end
         end
         run_len = 7'd0;
      endfunction

      function void note_input(rle_pkg::req_type it);
         int               first;
         rle_pkg::rsp_type tail;
         first = expected_codes.size();
         items_seen++;
         if (run_len != 7'd0 && it.data_byte == held_value && run_len < max_run_used()) begin
            run_len++;
         end else begin
            flush_run();
            held_value = it.data_byte;
            run_len    = 7'd1;
         end
         if (it.end_of_stream) begin
            flush_run();
            streams_closed++;
         end
         // flag the item's final byte, and the stream's if it closed
         if (expected_codes.size() > first) begin
            tail = expected_codes.pop_back();
            tail.last_of_item = 1'b1;
            tail.stream_done  = it.end_of_stream;
            expected_codes.push_back(tail);
         end
      endfunction

      function void check_code(rle_pkg::rsp_type got);
         rle_pkg::rsp_type want;
         bytes_checked++;
         if (expected_codes.size() == 0) begin
            $error("unexpected code byte %h (last_of_item %b, stream_done %b)",
                   got.code_byte, got.last_of_item, got.stream_done);
            errors++;
            return;
         end
         want = expected_codes.pop_front();
         if (got.code_byte !== want.code_byte) begin
            $error("code_byte: expected %h, got %h", want.code_byte, got.code_byte);
            errors++;
         end
         if (got.last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %b, got %b", want.last_of_item, got.last_of_item);
            errors++;
         end
         if (got.stream_done !== want.stream_done) begin
            $error("stream_done: expected %b, got %b", want.stream_done, got.stream_done);
            errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   rle_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   rle_pkg::rsp_type               rsp_data;
   logic                           csr_write_en = 1'b0;
   logic [rle_pkg::CSR_IDX_W-1:0]  csr_index = rle_pkg::CSR_MIN_RUN;
   logic [rle_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   rle_code_scoreboard sb;

   // idling mix of the current phase, in percent
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // per-segment register settings and item count
   localparam int NUM_SEGS = 8;
   localparam int SEG_ITEMS = 26;
   logic [rle_pkg::CSR_DATA_W-1:0] seg_min [NUM_SEGS] = '{7'd2, 7'd1, 7'd32, 7'd0,
                                                           7'h7F, 7'd3, 7'd5, 7'd32};
   logic [rle_pkg::CSR_DATA_W-1:0] seg_max [NUM_SEGS] = '{7'd127, 7'd1, 7'd127, 7'd0,
                                                           7'd127, 7'd64, 7'd2, 7'd33};

   rle_byte_encoder u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop; far beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: sample pre-edge values, then pick the stall for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_code(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Offer one item, with random idle cycles first; returns in the time step of
   // the edge that took it, valid still high.
   task automatic send_item(input logic [7:0] b, input logic eos);
      rle_pkg::req_type it;
      it.data_byte     = b;
      it.end_of_stream = eos;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      sb.note_input(it);
   endtask

   task automatic send_run(input logic [7:0] b, input int len, input logic eos_last);
      for (int k = 0; k < len; k++)
         send_item(b, eos_last && (k == len - 1));
   endtask

   // Must follow a send in the same time step: drops valid once.
   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   // Wait out every expected byte, then let a run still settling finish.
   task automatic drain();
      while (sb.expected_codes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Both registers, back to back; enable drops once at the end.
   task automatic write_regs(input logic [rle_pkg::CSR_DATA_W-1:0] min_v,
                             input logic [rle_pkg::CSR_DATA_W-1:0] max_v);
      csr_write_en <= 1'b1;
      csr_index    <= rle_pkg::CSR_MIN_RUN;
      csr_wdata    <= min_v;
      @(posedge clock);
      sb.set_reg(rle_pkg::CSR_MIN_RUN, min_v);
      csr_index    <= rle_pkg::CSR_MAX_RUN;
      csr_wdata    <= max_v;
      @(posedge clock);
      sb.set_reg(rle_pkg::CSR_MAX_RUN, max_v);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Bias toward the escape boundary and the byte extremes.
   function automatic logic [7:0] pick_value();
      case ($urandom_range(3))
         0:       return 8'($urandom_range(0, 127));
         1:       return 8'($urandom_range(128, 255));
         2: begin
            case ($urandom_range(4))
               0:       return 8'h00;
               1:       return 8'h7F;
               2:       return 8'h80;
               3:       return 8'h81;
               default: return 8'hFF;
            endcase
         end
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly whole runs of random length, some lone noise bytes; streams close
   // at random so both the held-run and fresh-stream paths get exercised.
   task automatic random_segment(input int n_items);
      int         sent;
      int         len;
      logic [7:0] v;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            send_item(8'($urandom), $urandom_range(9) == 0);
            sent++;
         end else begin
            v = pick_value();
            case ($urandom_range(39))
               0:          len = $urandom_range(100, 140);
               1, 2, 3, 4,
               5, 6:       len = $urandom_range(28, 36);
               default:    len = $urandom_range(1, 6);
            endcase
            send_run(v, len, $urandom_range(4) == 0);
            sent += len;
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings (min 2, max 127): lone literal, escaped
      // literal, same byte again after end of stream, short marker run.
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(8'hFF, 1'b1);
      send_run(8'h41, 2, 1'b1);
      send_item(8'h80, 1'b0);
      send_run(8'h7F, 2, 1'b1);
      stop_sending();
      drain();

      // Both registers zero: every byte is its own marker pair.
      write_regs(7'd0, 7'd0);
      send_run(8'h55, 2, 1'b1);
      stop_sending();
      drain();

      // Hold a run of four, then lower max below it and push min past 32.
      write_regs(7'd2, 7'd127);
      send_run(8'h10, 4, 1'b0);
      stop_sending();
      drain();
      write_regs(7'h7F, 7'd3);
      send_item(8'h10, 1'b0);
      send_item(8'h90, 1'b1);
      stop_sending();
      drain();

      // Random segments: each changes the settings (often with a run held)
      // and cycles the idling mix: none, sender, receiver, both.
      for (int seg = 0; seg < NUM_SEGS; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         write_regs(seg_min[seg], seg_max[seg]);
         if (seg == 0) begin
            // run past the 127 count cap
            send_run(8'hE7, 130, 1'b1);
         end else if (seg == 2) begin
            // worst load: 31 escaped literals plus an escaped closing byte
            send_run(8'hC3, 31, 1'b0);
            send_item(8'hA5, 1'b1);
         end
         random_segment(SEG_ITEMS);
         stop_sending();
         drain();
      end

      if (sb.expected_codes.size() != 0) begin
         $error("%0d code bytes never arrived", sb.expected_codes.size());
         sb.errors++;
      end
      $display("Encoded %0d items into %0d checked code bytes, %0d streams closed.",
               sb.items_seen, sb.bytes_checked, sb.streams_closed);
      $display("Register writes: %0d (min run 0..63, max run 0..127), four idling mixes.",
               sb.reg_writes);
      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
